// ===== rtl/vsh_pkg.sv =====
// Shared constants, types and the arctangent table for the velocity speed and heading block.
package vsh_pkg;

    localparam int CORDIC_STAGES = 16;              // rotation stages, 12..24
    localparam int TABLE_LEN     = 24;              // tabulated arctangents
    localparam int FRAC_BITS     = 20;              // fraction bits on x and y
    localparam int SQRT_STEPS    = 16;              // one result bit per step
    localparam int CORDIC_RUN    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int NUM_ITER      = (CORDIC_RUN > SQRT_STEPS) ? CORDIC_RUN : SQRT_STEPS;
    localparam int IDX_W         = $clog2(NUM_ITER);
    localparam int VW            = 16;              // velocity word width
    localparam int CW            = VW + FRAC_BITS + 4;  // x/y width with gain headroom
    localparam int AW            = 32;              // angle: 2^32 is one turn
    localparam int SW            = 32;              // sum of squares width
    localparam int PW            = AW + 16;         // angle times scale
    localparam int DATA_W        = 48;              // three packed 16-bit fields

    localparam logic [15:0]   HEADING_SCALE = 16'd36000;  // hundredths of a degree per turn
    localparam logic [AW-1:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [PW-1:0] ROUND_HALF    = PW'(64'h8000_0000);

    // One lane of the iteration pipeline: CORDIC state and square-root state.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [AW-1:0]        ang;
        logic                 zf;      // east and north both zero
        logic [SW-1:0]        op;      // square-root remainder
        logic [SW-1:0]        res;     // square-root partial root
        logic signed [VW-1:0] up;
    } t_lane;

    // atan(2^-i) as a fraction of a full turn
    function automatic logic [AW-1:0] atan_turn(input logic [4:0] idx);
        logic [AW-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/vsh_prep.sv =====
// Front stages: input capture, squares and half-plane fold, sum of squares.
module vsh_prep import vsh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  logic signed [VW-1:0] i_east,
    input  logic signed [VW-1:0] i_north,
    input  logic signed [VW-1:0] i_up,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output t_lane                o_lane
);

    logic                 r_vld0, r_vld1, r_vld2;
    logic                 adv0, adv1, adv2;
    logic signed [VW-1:0] r_east, r_north, r_up0, r_up1;
    logic signed [2*VW-1:0] r_ee, r_nn;
    logic signed [CW-1:0] r_x, r_y;
    logic [AW-1:0]        r_ang;
    logic                 r_zf;
    t_lane                r_lane;

    logic signed [CW-1:0] n_x, n_y;
    logic [AW-1:0]        n_ang;

    assign adv2  = ~r_vld2 | i_rdy;
    assign adv1  = ~r_vld1 | adv2;
    assign adv0  = ~r_vld0 | adv1;
    assign o_rdy = adv0;
    assign o_vld = r_vld2;
    assign o_lane = r_lane;

    // fold the left half-plane (north < 0) onto the right by a half turn
    always_comb begin
        n_x   = CW'(r_north) <<< FRAC_BITS;
        n_y   = CW'(r_east) <<< FRAC_BITS;
        n_ang = '0;
        if (r_north < 0) begin
            n_x   = -n_x;
            n_y   = -n_y;
            n_ang = HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (adv0) r_vld0 <= i_vld;
            if (adv1) r_vld1 <= r_vld0;
            if (adv2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_east  <= i_east;
            r_north <= i_north;
            r_up0   <= i_up;
        end
        if (adv1) begin
            r_ee  <= r_east * r_east;
            r_nn  <= r_north * r_north;
            r_x   <= n_x;
            r_y   <= n_y;
            r_ang <= n_ang;
            r_zf  <= (r_east == '0) && (r_north == '0);
            r_up1 <= r_up0;
        end
        if (adv2) begin
            r_lane.x   <= r_x;
            r_lane.y   <= r_y;
            r_lane.ang <= r_ang;
            r_lane.zf  <= r_zf;
            r_lane.op  <= unsigned'(r_ee) + unsigned'(r_nn);
            r_lane.res <= '0;
            r_lane.up  <= r_up1;
        end
    end

endmodule

// ===== rtl/vsh_iter.sv =====
// One pipeline stage: a CORDIC vectoring step and a square-root digit step.
module vsh_iter import vsh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,     // stage number, tied to a constant
    input  logic             i_vld,
    output logic             o_rdy,
    input  t_lane            i_lane,
    output logic             o_vld,
    input  logic             i_rdy,
    output t_lane            o_lane
);

    logic  r_vld;
    logic  adv;
    t_lane r_lane;
    t_lane n_lane;

    assign adv    = ~r_vld | i_rdy;
    assign o_rdy  = adv;
    assign o_vld  = r_vld;
    assign o_lane = r_lane;

    always_comb begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic [4:0]           sq_sh;
        logic [SW-1:0]        one;
        logic [SW:0]          trial;
        n_lane = i_lane;
        dx     = i_lane.y >>> i_idx;
        dy     = i_lane.x >>> i_idx;
        sq_sh  = 5'd30 - 5'({i_idx, 1'b0});
        one    = SW'(1) << sq_sh;
        trial  = {1'b0, i_lane.res} + {1'b0, one};
        if (int'(i_idx) < CORDIC_RUN) begin
            if (i_lane.y > 0) begin
                n_lane.x   = i_lane.x + dx;
                n_lane.y   = i_lane.y - dy;
                n_lane.ang = i_lane.ang + atan_turn(5'(i_idx));
            end else begin
                n_lane.x   = i_lane.x - dx;
                n_lane.y   = i_lane.y + dy;
                n_lane.ang = i_lane.ang - atan_turn(5'(i_idx));
            end
        end
        if (int'(i_idx) < SQRT_STEPS) begin
            if ({1'b0, i_lane.op} >= trial) begin
                n_lane.op  = i_lane.op - trial[SW-1:0];
                n_lane.res = (i_lane.res >> 1) + one;
            end else begin
                n_lane.res = i_lane.res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lane <= n_lane;
        end
    end

endmodule

// ===== rtl/vsh_post.sv =====
// Back stages: speed rounding, angle scaling to hundredths of a degree, wrap.
module vsh_post import vsh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  t_lane                i_lane,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output logic [15:0]          o_speed,
    output logic [15:0]          o_heading,
    output logic signed [VW-1:0] o_vert
);

    logic                 r_vld0, r_vld1;
    logic                 adv0, adv1;
    logic [PW-1:0]        r_prod;
    logic [15:0]          r_spd0, r_spd1, r_hdg;
    logic                 r_zf;
    logic signed [VW-1:0] r_up0, r_up1;
    logic [15:0]          n_spd, n_hdg;
    logic [PW-1:0]        rnd;

    assign adv1      = ~r_vld1 | i_rdy;
    assign adv0      = ~r_vld0 | adv1;
    assign o_rdy     = adv0;
    assign o_vld     = r_vld1;
    assign o_speed   = r_spd1;
    assign o_heading = r_hdg;
    assign o_vert    = r_up1;

    // round the root up when the remainder exceeds it
    assign n_spd = (i_lane.op > i_lane.res) ? 16'(i_lane.res + 1'b1) : 16'(i_lane.res);

    assign rnd = r_prod + ROUND_HALF;
    always_comb begin
        n_hdg = rnd[PW-1:AW];
        if (n_hdg >= HEADING_SCALE || r_zf) begin
            n_hdg = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (adv0) r_vld0 <= i_vld;
            if (adv1) r_vld1 <= r_vld0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_prod <= PW'(i_lane.ang) * PW'(HEADING_SCALE);
            r_spd0 <= n_spd;
            r_zf   <= i_lane.zf;
            r_up0  <= i_lane.up;
        end
        if (adv1) begin
            r_spd1 <= r_spd0;
            r_hdg  <= n_hdg;
            r_up1  <= r_up0;
        end
    end

endmodule

// ===== rtl/velocity_speed_and_heading.sv =====
// Top level: pipelined horizontal speed and heading from east/north/up velocity words.
//
// Takes one east/north/up velocity triple per item (LSB 1/200 m/s) and returns
// one item: horizontal speed round(sqrt(e^2+n^2)) in the same units, heading
// clockwise from north in hundredths of a degree (0..35999, zero vector gives 0),
// and the up word unchanged. Throughput is one item per clock while the output is not
// stalled; the path runs through the three front stages, one register per
// CORDIC/square-root step, and the scale and round stages.
// Each stage has its own valid bit and advances when empty or when the next stage
// moves, so a stalled output only holds the stages backed up behind it and bubbles
// ahead of it still fill. Items leave in the order they arrive.
module velocity_speed_and_heading import vsh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [15:0] east, [31:16] north, [47:32] up
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata    // [15:0] speed, [31:16] heading, [47:32] vertical
);

    t_lane w_lane [NUM_ITER+1];
    logic  w_vld  [NUM_ITER+1];
    logic  w_rdy  [NUM_ITER+1];

    logic [15:0]          w_speed, w_heading;
    logic signed [VW-1:0] w_vert;

    // capture, square, fold to the right half-plane, sum
    vsh_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_east  (signed'(i_s_tdata[15:0])),
        .i_north (signed'(i_s_tdata[31:16])),
        .i_up    (signed'(i_s_tdata[47:32])),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_lane  (w_lane[0])
    );

    // one CORDIC step and one root bit per stage
    for (genvar g = 0; g < NUM_ITER; g++) begin : g_iter
        vsh_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_lane  (w_lane[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    // angle to hundredths of a degree, round, wrap; last register is the output
    vsh_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_vld[NUM_ITER]),
        .o_rdy     (w_rdy[NUM_ITER]),
        .i_lane    (w_lane[NUM_ITER]),
        .o_vld     (o_m_tvalid),
        .i_rdy     (i_m_tready),
        .o_speed   (w_speed),
        .o_heading (w_heading),
        .o_vert    (w_vert)
    );

    assign o_m_tdata = {w_vert, w_heading, w_speed};

    // heading never reaches a full turn
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[31:16] < HEADING_SCALE))
        else $error("heading out of range");

    // speed stays within the largest possible magnitude
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:0] <= 16'd46341))
        else $error("speed out of range");

    // zero speed only comes from a zero vector, whose heading is zero
    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[15:0] == '0)) |-> (o_m_tdata[31:16] == '0))
        else $error("zero vector with nonzero heading");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");

endmodule
